[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge outside reset
`define TDS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tds assertion failed");

// Checked on every rising edge, reset included
`define TDS_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("tds assertion failed");

`else

`define TDS_ASSERT(lbl, clk, rst_n, prop)
`define TDS_ASSERT_NR(lbl, clk, prop)

`endif

`endif

[rtl/tds_pkg.sv]
`default_nettype none

package tds_pkg;

    // Shape limits
    localparam longint unsigned RAND_LIMIT = 32767;
    localparam int unsigned     MAX_SPAN   = 256;

    // Widths
    localparam int DATA_W    = 32;
    localparam int VAL_W     = 16;
    localparam int DIFF_W    = VAL_W + 1;
    localparam int SPAN_W    = $clog2(MAX_SPAN + 1);
    localparam int STEP_W    = $clog2(MAX_SPAN);
    localparam int PMASS_W   = $clog2(RAND_LIMIT + 1);
    localparam int DIV_CNT_W = $clog2(DATA_W);
    localparam int CFG_IDX_W = 2;

    // Numerator of the peak mass
    localparam logic [DATA_W-1:0] PEAK_MASS_NUM = DATA_W'(RAND_LIMIT * 2);

    // Register reset values
    localparam logic signed [VAL_W-1:0] LOW_RESET  = 16'sd0;
    localparam logic signed [VAL_W-1:0] PEAK_RESET = 16'sd8;
    localparam logic signed [VAL_W-1:0] HIGH_RESET = 16'sd16;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW  = 2'd0,
        REG_PEAK = 2'd1,
        REG_HIGH = 2'd2
    } t_cfg_reg;

    // Divisions run on the shared divider
    typedef enum logic [1:0] {
        DIV_PMASS,
        DIV_RISE,
        DIV_FALL,
        DIV_TARGET
    } t_div_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MASS,
        ST_WALK,
        ST_OUTPUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic    load_word;
        logic    derive;
        logic    div_start;
        t_div_op div_op;
        logic    div_store;
        logic    walk_init;
        logic    walk_step;
        logic    mass_store;
        logic    out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic derived_ready;
        logic cfg_bad;
        logic cfg_invalid;
        logic div_busy;
        logic div_done;
        logic walk_last;
        logic walk_hit;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

[rtl/tds_in_if.sv]
`default_nettype none

interface tds_in_if import tds_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

[rtl/tds_out_if.sv]
`default_nettype none

interface tds_out_if import tds_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] sample;
    logic                    config_error;

    modport source (output valid, output sample, output config_error, input ready);
    modport sink   (input valid, input sample, input config_error, output ready);
endinterface

`default_nettype wire

[rtl/tds_cfg_if.sv]
`default_nettype none

interface tds_cfg_if import tds_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [VAL_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/tds_div.sv]
`default_nettype none

`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle
module tds_div import tds_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DATA_W-1:0] i_dividend,
    input  wire logic [DATA_W-1:0] i_divisor,
    output logic                   o_busy,
    output logic                   o_done,
    output logic [DATA_W-1:0]      o_quotient,
    output logic [DATA_W-1:0]      o_remainder
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0]    r_quo;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_div;

    logic [DATA_W:0]      shifted;
    logic                 fits;
    logic [DATA_W-1:0]    n_rem;

    // Trial subtraction of the divisor from the shifted remainder
    always_comb begin
        shifted = {r_rem, r_quo[DATA_W-1]};
        fits    = (shifted >= {1'b0, r_div});
        n_rem   = fits ? DATA_W'(shifted - {1'b0, r_div}) : shifted[DATA_W-1:0];
    end

    // Control: run one pass of DATA_W steps per start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operands and partial results
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DATA_W-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    `TDS_ASSERT_NR(a_div_reset_idle, i_clk, !i_rst_n |=> !r_busy && !r_done)
    `TDS_ASSERT(a_div_done_after_busy, i_clk, i_rst_n, r_done |-> $past(r_busy))

endmodule

`default_nettype wire

[rtl/tds_datapath.sv]
`default_nettype none

`include "assert_macros.svh"

module tds_datapath import tds_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    output t_dp_status                   o_status,
    input  wire logic [DATA_W-1:0]       i_word,
    input  wire logic                    i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [VAL_W-1:0]        i_cfg_data,
    output logic                         o_cfg_ready,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [VAL_W-1:0]      o_sample,
    output logic                         o_config_error
);

    localparam logic signed [DIFF_W-1:0] SPAN_LIMIT = DIFF_W'(MAX_SPAN);

    // Configuration and derived state
    logic signed [VAL_W-1:0] r_low;
    logic signed [VAL_W-1:0] r_peak;
    logic signed [VAL_W-1:0] r_high;
    logic                    r_derived_ready;
    logic                    r_cfg_bad;
    logic [PMASS_W-1:0]      r_pmass;
    logic [DATA_W-1:0]       r_rise;
    logic [DATA_W-1:0]       r_fall;
    logic [DATA_W-1:0]       r_total;

    // Per-request state
    logic [DATA_W-1:0]       r_word;
    logic [DATA_W-1:0]       r_target;
    logic [DATA_W-1:0]       r_w;
    logic [DATA_W-1:0]       r_cum;
    logic [STEP_W-1:0]       r_step;

    // Result register
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_sample;
    logic                    r_config_error;

    logic signed [DIFF_W-1:0] d_lp;
    logic signed [DIFF_W-1:0] d_hp;
    logic signed [DIFF_W-1:0] d_hl;
    logic                     cfg_invalid;
    logic [SPAN_W-1:0]        span;
    logic [SPAN_W-1:0]        rise_len;
    logic [SPAN_W-1:0]        fall_len;
    logic [DATA_W-1:0]        delta;
    logic [DATA_W-1:0]        w_next;
    logic [DATA_W-1:0]        cum_next;
    logic                     walk_hit;
    logic                     walk_last;
    logic [VAL_W-1:0]         hit_value;
    logic [DATA_W-1:0]        div_dividend;
    logic [DATA_W-1:0]        div_divisor;
    logic                     div_busy;
    logic                     div_done;
    logic [DATA_W-1:0]        div_quotient;
    logic [DATA_W-1:0]        div_remainder;

    // Shape of the triangle from the registers
    always_comb begin
        d_lp        = DIFF_W'(r_peak) - DIFF_W'(r_low);
        d_hp        = DIFF_W'(r_high) - DIFF_W'(r_peak);
        d_hl        = DIFF_W'(r_high) - DIFF_W'(r_low);
        cfg_invalid = !((d_lp > 0) && (d_hp > 0) && (d_hl <= SPAN_LIMIT));
        span        = d_hl[SPAN_W-1:0];
        rise_len    = d_lp[SPAN_W-1:0];
        fall_len    = d_hp[SPAN_W-1:0];
    end

    // Weight change for the current value, then the running sums
    always_comb begin
        priority if (r_step == '0) begin
            delta = r_rise >> 1;
        end else if (SPAN_W'(r_step) < rise_len) begin
            delta = r_rise;
        end else if (SPAN_W'(r_step) == rise_len) begin
            delta = (r_rise >> 1) - (r_fall >> 1);
        end else begin
            delta = '0 - r_fall;
        end
        w_next    = r_w + delta;
        cum_next  = r_cum + w_next;
        walk_hit  = (r_target < cum_next);
        walk_last = (SPAN_W'(r_step) == SPAN_W'(span - 1'b1));
        hit_value = r_low + VAL_W'(r_step);
    end

    // Divider operands per operation
    always_comb begin
        unique case (i_cmd.div_op)
            DIV_PMASS: begin
                div_dividend = PEAK_MASS_NUM;
                div_divisor  = DATA_W'(span);
            end
            DIV_RISE: begin
                div_dividend = DATA_W'(r_pmass);
                div_divisor  = DATA_W'(rise_len);
            end
            DIV_FALL: begin
                div_dividend = DATA_W'(r_pmass);
                div_divisor  = DATA_W'(fall_len);
            end
            DIV_TARGET: begin
                div_dividend = r_word;
                div_divisor  = r_total;
            end
            default: begin
                div_dividend = r_word;
                div_divisor  = r_total;
            end
        endcase
    end

    tds_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_busy      (div_busy),
        .o_done      (div_done),
        .o_quotient  (div_quotient),
        .o_remainder (div_remainder)
    );

    // Configuration writes and derivation flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low           <= LOW_RESET;
            r_peak          <= PEAK_RESET;
            r_high          <= HIGH_RESET;
            r_derived_ready <= 1'b0;
            r_cfg_bad       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_LOW: begin
                        r_low           <= i_cfg_data;
                        r_derived_ready <= 1'b0;
                    end
                    REG_PEAK: begin
                        r_peak          <= i_cfg_data;
                        r_derived_ready <= 1'b0;
                    end
                    REG_HIGH: begin
                        r_high          <= i_cfg_data;
                        r_derived_ready <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.derive) begin
                r_cfg_bad <= cfg_invalid;
                if (cfg_invalid) begin
                    r_derived_ready <= 1'b1;
                end
            end
            if (i_cmd.mass_store) begin
                r_derived_ready <= 1'b1;
            end
        end
    end

    // Derived steps, target and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) begin
            r_word <= i_word;
        end
        if (i_cmd.derive && cfg_invalid) begin
            r_rise  <= '0;
            r_fall  <= '0;
            r_total <= '0;
        end
        if (i_cmd.div_store) begin
            unique case (i_cmd.div_op)
                DIV_PMASS:  r_pmass  <= div_quotient[PMASS_W-1:0];
                DIV_RISE:   r_rise   <= div_quotient;
                DIV_FALL:   r_fall   <= div_quotient + 1'b1;
                DIV_TARGET: r_target <= (r_total == '0) ? '0 : div_remainder;
                default:    r_target <= '0;
            endcase
        end
        if (i_cmd.walk_init) begin
            r_w    <= '0;
            r_cum  <= '0;
            r_step <= '0;
        end else if (i_cmd.walk_step) begin
            r_w    <= w_next;
            r_cum  <= cum_next;
            r_step <= r_step + 1'b1;
        end
        if (i_cmd.mass_store) begin
            r_total <= cum_next;
        end
    end

    // Result register: hold until the receiver takes the sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_config_error <= r_cfg_bad;
            priority if (r_cfg_bad) begin
                r_sample <= r_low;
            end else if (walk_hit) begin
                r_sample <= hit_value;
            end else begin
                r_sample <= r_high;
            end
        end
    end

    always_comb begin
        o_status.derived_ready = r_derived_ready;
        o_status.cfg_bad       = r_cfg_bad;
        o_status.cfg_invalid   = cfg_invalid;
        o_status.div_busy      = div_busy;
        o_status.div_done      = div_done;
        o_status.walk_last     = walk_last;
        o_status.walk_hit      = walk_hit;
        o_status.out_free      = !r_out_valid || i_out_ready;
    end

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_sample       = r_sample;
    assign o_config_error = r_config_error;

    `TDS_ASSERT(a_bad_cfg_zero_state, i_clk, i_rst_n, (r_cfg_bad && r_derived_ready) |-> (r_rise == '0 && r_fall == '0 && r_total == '0))
    `TDS_ASSERT(a_fall_step_nonzero, i_clk, i_rst_n, (r_derived_ready && !r_cfg_bad) |-> (r_fall != '0))

endmodule

`default_nettype wire

[rtl/tds_ctrl.sv]
`default_nettype none

`include "assert_macros.svh"

module tds_ctrl import tds_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state  r_state;
    t_state  n_state;
    t_div_op r_op;
    t_div_op n_op;

    // State and pending division
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= DIV_PMASS;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        o_cmd        = '0;
        o_cmd.div_op = r_op;
        o_in_ready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_word = 1'b1;
                    if (!i_status.derived_ready) begin
                        o_cmd.derive = 1'b1;
                        if (i_status.cfg_invalid) begin
                            n_state = ST_OUTPUT;
                        end else begin
                            n_op    = DIV_PMASS;
                            n_state = ST_DIV_GO;
                        end
                    end else if (i_status.cfg_bad) begin
                        n_state = ST_OUTPUT;
                    end else begin
                        n_op    = DIV_TARGET;
                        n_state = ST_DIV_GO;
                    end
                end
            end
            ST_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.div_store = 1'b1;
                    unique case (r_op)
                        DIV_PMASS: begin
                            n_op    = DIV_RISE;
                            n_state = ST_DIV_GO;
                        end
                        DIV_RISE: begin
                            n_op    = DIV_FALL;
                            n_state = ST_DIV_GO;
                        end
                        DIV_FALL: begin
                            o_cmd.walk_init = 1'b1;
                            n_state         = ST_MASS;
                        end
                        DIV_TARGET: begin
                            o_cmd.walk_init = 1'b1;
                            n_state         = ST_WALK;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MASS: begin
                // Accumulate the total mass over the whole span
                o_cmd.walk_step = 1'b1;
                if (i_status.walk_last) begin
                    o_cmd.mass_store = 1'b1;
                    n_op             = DIV_TARGET;
                    n_state          = ST_DIV_GO;
                end
            end
            ST_WALK: begin
                // Stop on the first value past the target or at the top
                if (i_status.walk_hit || i_status.walk_last) begin
                    n_state = ST_OUTPUT;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            ST_OUTPUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `TDS_ASSERT(a_div_start_free, i_clk, i_rst_n, o_cmd.div_start |-> (!i_status.div_busy && !i_status.div_done))
    `TDS_ASSERT(a_div_start_runs, i_clk, i_rst_n, o_cmd.div_start |=> i_status.div_busy)
    `TDS_ASSERT(a_out_load_free, i_clk, i_rst_n, o_cmd.out_load |-> i_status.out_free)

endmodule

`default_nettype wire

[rtl/triangular_distribution_sampler.sv]
// Triangular distribution sampler.
// i_req carries one 32-bit uniform random word per request; o_rsp returns one
// signed 16-bit sample and a config_error flag for each request, in order.
// i_cfg writes low (index 0), peak (index 1) and high (index 2); it is always
// ready, unused indexes are ignored, and writes belong only in idle periods.
// A request runs through one 32-step serial divider (word modulo total mass),
// walks the span (at most 256 values) one value per cycle until the running
// weight passes the target or the walk reaches the top value, and then loads
// the output register once it is free. The first request after reset or a
// register write also derives the peak mass, rising and falling steps (three
// divisions) and the total mass (one walk over the span).
// An invalid setting returns low with config_error set.
// One request is in work at a time; the next one is taken as soon as the
// result sits in the output register, even while the receiver stalls it.
// Reset restores low 0, peak 8, high 16 and marks the derived values stale.
`default_nettype none

module triangular_distribution_sampler import tds_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tds_in_if.sink     i_req,
    tds_out_if.source  o_rsp,
    tds_cfg_if.sink    i_cfg
);

    t_dp_cmd    cmd;
    t_dp_status status;

    tds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tds_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_word         (i_req.random_word),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_cfg_ready    (i_cfg.ready),
        .o_out_valid    (o_rsp.valid),
        .i_out_ready    (o_rsp.ready),
        .o_sample       (o_rsp.sample),
        .o_config_error (o_rsp.config_error)
    );

endmodule

`default_nettype wire

[verif/tds_sample_check.sv]
`default_nettype none

module tds_sample_check import tds_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tds_in_if         i_req,
    tds_out_if        o_rsp,
    tds_cfg_if        i_cfg,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct packed {
        logic signed [VAL_W-1:0] sample;
        logic                    config_error;
    } t_sample_rsp;

    // Register copies and the shape derived from them
    logic signed [VAL_W-1:0] cfg_low;
    logic signed [VAL_W-1:0] cfg_peak;
    logic signed [VAL_W-1:0] cfg_high;
    logic [DATA_W-1:0]       rise_amt;
    logic [DATA_W-1:0]       fall_amt;
    logic [DATA_W-1:0]       mass_total;
    bit                      shape_fresh;
    bit                      shape_bad;

    t_sample_rsp sample_q[$];
    t_sample_rsp want;

    // Advance the per-value weight by one step of the walk
    function automatic logic [DATA_W-1:0] weight_after(logic [DATA_W-1:0] w, int v,
                                                       int lo, int pk);
        if (v == lo)
            return w + (rise_amt >> 1);
        if (v < pk)
            return w + rise_amt;
        if (v == pk)
            return w + ((rise_amt >> 1) - (fall_amt >> 1));
        return w - fall_amt;
    endfunction

    // Recompute the steps and total mass from the current registers
    function automatic void rebuild_shape();
        int                lo;
        int                pk;
        int                hi;
        logic [DATA_W-1:0] peak_mass;
        logic [DATA_W-1:0] w;
        lo = int'(cfg_low);
        pk = int'(cfg_peak);
        hi = int'(cfg_high);
        rise_amt   = '0;
        fall_amt   = '0;
        mass_total = '0;
        shape_bad  = !(lo < pk && pk < hi && (hi - lo) <= int'(MAX_SPAN));
        if (!shape_bad) begin
            peak_mass = PEAK_MASS_NUM / DATA_W'(hi - lo);
            rise_amt  = peak_mass / DATA_W'(pk - lo);
            fall_amt  = peak_mass / DATA_W'(hi - pk) + 1;
            w = '0;
            for (int v = lo; v < hi; v++) begin
                w = weight_after(w, v, lo, pk);
                mass_total += w;
            end
        end
        shape_fresh = 1'b1;
    endfunction

    // Map one random word onto the cumulative weights
    function automatic t_sample_rsp draw_sample(logic [DATA_W-1:0] word);
        t_sample_rsp       r;
        int                lo;
        int                pk;
        int                hi;
        logic [DATA_W-1:0] target;
        logic [DATA_W-1:0] w;
        logic [DATA_W-1:0] cum;
        if (!shape_fresh)
            rebuild_shape();
        lo = int'(cfg_low);
        pk = int'(cfg_peak);
        hi = int'(cfg_high);
        if (shape_bad) begin
            r.sample       = cfg_low;
            r.config_error = 1'b1;
            return r;
        end
        target = (mass_total != 0) ? word % mass_total : '0;
        r.sample       = cfg_high;
        r.config_error = 1'b0;
        w   = '0;
        cum = '0;
        for (int v = lo; v < hi; v++) begin
            w = weight_after(w, v, lo, pk);
            cum += w;
            if (target < cum) begin
                r.sample = VAL_W'(v);
                break;
            end
        end
        return r;
    endfunction

    // Track register writes, predict on each request, compare each result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_low      = LOW_RESET;
            cfg_peak     = PEAK_RESET;
            cfg_high     = HIGH_RESET;
            rise_amt     = '0;
            fall_amt     = '0;
            mass_total   = '0;
            shape_fresh  = 1'b0;
            shape_bad    = 1'b0;
            sample_q.delete();
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_LOW: begin
                        cfg_low     = i_cfg.data;
                        shape_fresh = 1'b0;
                    end
                    REG_PEAK: begin
                        cfg_peak    = i_cfg.data;
                        shape_fresh = 1'b0;
                    end
                    REG_HIGH: begin
                        cfg_high    = i_cfg.data;
                        shape_fresh = 1'b0;
                    end
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready)
                sample_q.push_back(draw_sample(i_req.random_word));
            if (o_rsp.valid && o_rsp.ready) begin
                if (sample_q.size() == 0) begin
                    $error("unexpected sample %0d, config_error %0b",
                           o_rsp.sample, o_rsp.config_error);
                    o_fail_count++;
                end else begin
                    want = sample_q.pop_front();
                    if (o_rsp.sample !== want.sample) begin
                        $error("sample: expected %0d, actual %0d", want.sample, o_rsp.sample);
                        o_fail_count++;
                    end
                    if (o_rsp.config_error !== want.config_error) begin
                        $error("config_error: expected %0b, actual %0b",
                               want.config_error, o_rsp.config_error);
                        o_fail_count++;
                    end
                end
            end
            o_pending = sample_q.size();
        end
    end

endmodule

`default_nettype wire

[verif/tb_triangular_distribution_sampler.sv]
`default_nettype none

module tb_triangular_distribution_sampler;
    import tds_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 2000;
    localparam int RANDOM_ITEMS   = 930;
    localparam int DRAIN_CYCLES   = 700;
    localparam int HOLD_PHASE     = 4;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   hold_off_go;

    logic [DATA_W-1:0] word_q[$];

    tds_in_if  req_ch ();
    tds_out_if rsp_ch ();
    tds_cfg_if cfg_ch ();

    triangular_distribution_sampler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    tds_sample_check u_sample_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .o_rsp        (rsp_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hold until every predicted sample has come back
    task automatic wait_idle();
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_shape(input int lo, input int pk, input int hi);
        wait_idle();
        write_reg(REG_LOW, VAL_W'(lo));
        write_reg(REG_PEAK, VAL_W'(pk));
        write_reg(REG_HIGH, VAL_W'(hi));
    endtask

    // Mostly well-formed shapes of random size; some broken ones and lone writes
    task automatic pick_shape();
        int span;
        int lo;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                span = $urandom_range(2, 24);
                lo   = int'($urandom_range(0, 65535 - span)) - 32768;
                set_shape(lo, lo + int'($urandom_range(1, span - 1)), lo + span);
            end
            5, 6: begin
                span = $urandom_range(2, MAX_SPAN);
                lo   = int'($urandom_range(0, 65535 - span)) - 32768;
                set_shape(lo, lo + int'($urandom_range(1, span - 1)), lo + span);
            end
            7: begin
                set_shape(int'($urandom_range(0, 65535)) - 32768,
                          int'($urandom_range(0, 65535)) - 32768,
                          int'($urandom_range(0, 65535)) - 32768);
            end
            8: begin
                span = int'(MAX_SPAN) + int'($urandom_range(1, 400));
                lo   = int'($urandom_range(0, 65535 - span)) - 32768;
                set_shape(lo, lo + int'($urandom_range(1, span - 1)), lo + span);
            end
            default: begin
                wait_idle();
                write_reg(CFG_IDX_W'($urandom_range(0, 3)), VAL_W'($urandom));
            end
        endcase
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 3))
            0, 1: return $urandom;
            2: return DATA_W'($urandom_range(0, 65535));
            default: return ~DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offer the queued words in bursts with random gaps between them
    task automatic send_queued_words();
        int burst;
        burst = 0;
        while (word_q.size() != 0) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 3) != 0) begin
                    @(negedge i_clk);
                    req_ch.valid <= 1'b0;
                    if ($urandom_range(0, 3) == 0)
                        repeat ($urandom_range(0, 30)) @(negedge i_clk);
                    else
                        repeat ($urandom_range(0, 4)) @(negedge i_clk);
                end
            end
            @(negedge i_clk);
            req_ch.valid       <= 1'b1;
            req_ch.random_word <= word_q.pop_front();
            @(posedge i_clk);
            while (!req_ch.ready) @(posedge i_clk);
            burst--;
        end
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
    endtask

    // Receiver: stall on a rotating pattern, once holding off for a long stretch
    initial begin : receiver
        logic [15:0] stall_mask;
        int          left;
        bit          hold_done;
        rsp_ch.ready = 1'b0;
        stall_mask   = '1;
        left         = 0;
        hold_done    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_go && !hold_done) begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_done = 1'b1;
            end
            if (left == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_mask = '1;
                    1: stall_mask = 16'($urandom);
                    2: stall_mask = 16'($urandom | $urandom);
                    default: stall_mask = 16'($urandom & $urandom);
                endcase
                left = $urandom_range(16, 96);
            end
            rsp_ch.ready <= stall_mask[left % 16];
            left--;
        end
    end

    // Watchdog: end the run after too long without any handshake
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_triangular_distribution_sampler NOT OK");
        $finish;
    end

    initial begin : stimulus
        int sent;
        int phase;
        int n;
        req_ch.valid       = 1'b0;
        req_ch.random_word = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_LOW;
        cfg_ch.data        = '0;
        hold_off_go        = 1'b0;
        i_rst_n            = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset shape, word extremes and alternating bits
        word_q = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
        send_queued_words();

        // Unused register index leaves the shape alone
        wait_idle();
        write_reg(REG_SPARE, 16'hFFFF);
        word_q = '{32'h0000_0007};
        send_queued_words();

        // Widest span at the bottom of the range, then at the top
        set_shape(-32768, -32767, -32512);
        word_q = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678};
        send_queued_words();
        set_shape(32511, 32766, 32767);
        word_q = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hDEAD_BEEF};
        send_queued_words();

        // Narrowest span
        set_shape(-1, 0, 1);
        word_q = '{32'h0000_0000, 32'hFFFF_FFFF};
        send_queued_words();

        // Invalid shapes: low at peak, peak at high, span too wide, reversed
        set_shape(5, 5, 9);
        word_q = '{32'h0000_0003};
        send_queued_words();
        set_shape(5, 9, 9);
        word_q = '{32'hFFFF_FFFF};
        send_queued_words();
        set_shape(0, 100, 257);
        word_q = '{32'h8000_0000};
        send_queued_words();
        set_shape(32767, 0, -32768);
        word_q = '{32'h0000_0000};
        send_queued_words();

        // Random phases, each with its own shape
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            pick_shape();
            n = $urandom_range(10, 60);
            for (int k = 0; k < n; k++)
                word_q.push_back(pick_word());
            if (phase == HOLD_PHASE)
                hold_off_go = 1'b1;
            send_queued_words();
            sent += n;
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_triangular_distribution_sampler OK");
        else
            $display("tb_triangular_distribution_sampler NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

[triangular_distribution_sampler.f]
+incdir+rtl
rtl/tds_pkg.sv
rtl/tds_in_if.sv
rtl/tds_out_if.sv
rtl/tds_cfg_if.sv
rtl/tds_div.sv
rtl/tds_datapath.sv
rtl/tds_ctrl.sv
rtl/triangular_distribution_sampler.sv
verif/tds_sample_check.sv
verif/tb_triangular_distribution_sampler.sv
